/* rtl/bdq_pkg.sv */
// bdq_pkg: field widths, stream packing and operation/status codes for the
// bounded deque core. No dependencies; imported by bounded_deque_with_indexed_read_core.
package bdq_pkg;

    localparam int OPCODE_W  = 3;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 7;

    // Stream packing, padded to whole bytes
    localparam int S_TDATA_W = 40;   // entry_data, position, pad
    localparam int M_TDATA_W = 40;   // result_data, fill_count, pad
    localparam int S_PAD_W   = S_TDATA_W - DATA_W - POS_W;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - FILL_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR      = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

endpackage

/* rtl/bounded_deque_with_indexed_read_core.sv */
// Bounded double-ended queue with indexed read: circular entry memory plus
// front pointer and fill count. Depends on bdq_pkg.

// Each request carries an opcode in s_axis_tuser (push back, push front, pop
// back, pop front, read by position, clear) and gives exactly one result with
// the word, a status in m_axis_tuser and the fill count after the operation.
// Entries live in a single-port synchronous memory of DEPTH words with a
// registered read (rd_data_reg). Pushes, clears, unused opcodes and refused
// requests (full, empty, out of range) go straight to the result register, so
// they stream at one request per cycle while the result register is drained.
// A pop or read that returns data passes through STATE_RDWAIT: the memory read
// issues when the request is accepted, the registered word is then copied into
// the result register, and s_axis_tready stays low in STATE_RDWAIT. A new
// request is taken only while the core is idle and the result register is
// empty or being taken in the same cycle. There is no clearing pass after
// reset: the memory is never read at an unwritten entry, so it starts accepting right away.
module bounded_deque_with_indexed_read_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] entry_data, [37:32] position, [39:38] zero
    input  logic [bdq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] opcode
    input  logic [bdq_pkg::OPCODE_W-1:0]   s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] result_data, [38:32] fill_count, [39] zero
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [bdq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import bdq_pkg::*;

    localparam int PW = $clog2(DEPTH);          // slot index width
    localparam int CW = $clog2(DEPTH + 1);      // count width, holds DEPTH
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW:0]   DEPTH_SUM  = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);

    typedef enum logic [1:0] {
        STATE_IDLE   = 2'b01,
        STATE_RDWAIT = 2'b10
    } state_t;

    state_t                state_reg;
    logic [PW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_data_reg;
    status_t               out_status_reg;
    logic [FILL_W-1:0]     out_fill_reg;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    opcode_t               op;
    status_t               status;
    logic [DATA_WIDTH-1:0] word;
    logic [MW-1:0]         pos_ext, count_ext;
    logic [CW-1:0]         count_dec;
    logic [PW-1:0]         front_dec, front_inc;
    logic [PW-1:0]         offset, slot_sum, addr;
    logic [PW:0]           sum, sum_wrap;
    logic                  use_front_dec;
    logic                  wr_en, rd_en;
    logic                  is_full, is_empty;
    logic                  accept, out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == STATE_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        op        = opcode_t'(s_axis_tuser);
        word      = DATA_WIDTH'(s_axis_tdata[DATA_W-1:0]);
        pos_ext   = MW'(s_axis_tdata[DATA_W +: POS_W]);
        count_ext = MW'(count_reg);
        is_full   = (count_reg == DEPTH_CNT);
        is_empty  = (count_reg == '0);
        count_dec = count_reg - 1'b1;
        front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
        front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;

        front_next    = front_reg;
        count_next    = count_reg;
        status        = STAT_OK;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        offset        = '0;
        use_front_dec = 1'b0;

        unique case (op)
            OP_PUSH_BACK: begin
                if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    wr_en      = 1'b1;
                    offset     = count_reg[PW-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    status = STAT_FULL;
                end else begin
                    wr_en         = 1'b1;
                    use_front_dec = 1'b1;
                    front_next    = front_dec;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    offset     = count_dec[PW-1:0];
                    count_next = count_dec;
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    front_next = front_inc;
                    count_next = count_dec;
                end
            end
            OP_READ: begin
                if (pos_ext >= count_ext) begin
                    status = STAT_RANGE;
                end else begin
                    rd_en  = 1'b1;
                    offset = pos_ext[PW-1:0];
                end
            end
            OP_CLEAR: begin
                if (is_empty) begin
                    status = STAT_EMPTY;
                end else begin
                    front_next = '0;
                    count_next = '0;
                end
            end
            default: begin
                // unused opcodes: no change, ok
            end
        endcase

        // front + offset, both below DEPTH, so one conditional subtract wraps it
        sum      = {1'b0, front_reg} + {1'b0, offset};
        sum_wrap = sum - DEPTH_SUM;
        slot_sum = (sum >= DEPTH_SUM) ? sum_wrap[PW-1:0] : sum[PW-1:0];
        addr     = use_front_dec ? front_dec : slot_sum;
    end

    // One access per request, so a read never meets a write in flight.
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            mem[addr] <= word;
        end
        if (accept && rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept && !rd_en) begin
                out_valid_reg <= 1'b1;
            end else if (state_reg == STATE_RDWAIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                STATE_IDLE: begin
                    if (accept) begin
                        front_reg <= front_next;
                        count_reg <= count_next;
                        if (rd_en) begin
                            state_reg <= STATE_RDWAIT;
                        end
                    end
                end
                STATE_RDWAIT: begin
                    state_reg <= STATE_IDLE;
                end
                default: begin
                    state_reg <= STATE_IDLE;
                end
            endcase
        end
    end

    // Status and count are fixed at accept; the word follows on a memory read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= status;
            out_fill_reg   <= FILL_W'(count_next);
            out_data_reg   <= '0;
        end else if (state_reg == STATE_RDWAIT) begin
            out_data_reg   <= DATA_W'(rd_data_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_fill_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("fill count above DEPTH");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_reg <= LAST_SLOT)
        else $error("front pointer outside the memory");

    a_rdwait_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == STATE_RDWAIT |-> !out_valid_reg)
        else $error("read data would overwrite a pending result");

    a_rdwait_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == STATE_RDWAIT |=> out_valid_reg && state_reg == STATE_IDLE)
        else $error("memory read did not produce a result");

    a_no_accept_in_rdwait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == STATE_RDWAIT |-> !s_axis_tready)
        else $error("request taken during memory read");
`endif

endmodule
